/* design/lgh_pkg.sv */
// ----------------------------------------------------------------------------
// lgh_pkg
// Shared codes, types and helpers for the log2 latency histogram unit.
// ----------------------------------------------------------------------------
package lgh_pkg;

   // request codes
   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // percentile limits
   localparam logic [6:0] PCT_MIN = 7'd1;
   localparam logic [6:0] PCT_MAX = 7'd99;

   // lowest bucket covers everything below 2^6 ns
   localparam int unsigned BUCKET_SHIFT = 5;

   // commands for the accumulate and compare unit
   typedef enum logic [1:0] {
      ACC_HOLD  = 2'd0,
      ACC_CLEAR = 2'd1,
      ACC_ADD   = 2'd2
   } acc_op_type;

   // bucket index: floor(log2(ns)) - 5, held between 0 and nb-1
   function automatic logic [5:0] bucket_of(input logic [63:0] ns, input int unsigned nb);
      logic [63:0] v;
      logic [5:0]  top;
      logic [5:0]  idx;
      int          k;
      v   = ns;
      top = '0;
      // binary search for the leading one
      for (k = 5; k >= 0; k--) begin
         if ((v >> (1 << k)) != 64'd0) begin
            top[k] = 1'b1;
            v      = v >> (1 << k);
         end
      end
      idx = (top >= 6'(BUCKET_SHIFT)) ? top - 6'(BUCKET_SHIFT) : 6'd0;
      if (idx > 6'(nb - 1)) begin
         idx = 6'(nb - 1);
      end
      return idx;
   endfunction

endpackage

/* design/log2_latency_histogram_unit.sv */
// ----------------------------------------------------------------------------
// log2_latency_histogram_unit
// Log2 bucket latency histogram with totals, min/max and percentile query.
// ----------------------------------------------------------------------------
// Usage:
//  A transaction is taken on a rising edge with start high and busy low.
//  req_type selects record (add req_latency_ns), percentile query
//  (req_percent) or clear; any other code only reports the current state.
//  Every transaction gives exactly one result, shown for one cycle with
//  rsp_valid high; the receiver cannot stall, so it must sample then.
//  Steps from the accepting edge to the strobe cycle:
//    record                      : bucket read, then write back
//    clear, unknown, empty query : strobe in the next cycle
//    query                       : setup, then a walk of one bucket per cycle
//                                  through the accumulator
//  busy stays high while a record or query is in progress; start may be
//  raised again in the strobe cycle.
//  Reset and clear empty all buckets at once through per-entry valid bits
//  and zero the count, sum, min and max.
// ----------------------------------------------------------------------------
module log2_latency_histogram_unit #(
   parameter int unsigned NUM_BUCKETS = 32,
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_latency_ns,
   input  logic [6:0]  req_percent,
   output logic        rsp_valid,
   output logic [63:0] rsp_percentile_ns,
   output logic [31:0] rsp_sample_count,
   output logic [63:0] rsp_sample_sum,
   output logic [63:0] rsp_min_latency,
   output logic [63:0] rsp_max_latency
);
   import lgh_pkg::*;

   localparam int unsigned AddrWidth = $clog2(NUM_BUCKETS);
   localparam logic [AddrWidth-1:0]   LastIdx   = AddrWidth'(NUM_BUCKETS - 1);
   localparam logic [COUNT_WIDTH-1:0] CountMax  = '1;
   localparam logic [63:0]            TopAnswer = 64'd1 << (NUM_BUCKETS + 4);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_REC_RD    = 5'b00010,
      ST_REC_WR    = 5'b00100,
      ST_QRY_SETUP = 5'b01000,
      ST_QRY_WALK  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [63:0]            answer_ff, answer_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [63:0]            sum_ff, sum_in;
   logic [63:0]            min_ff, min_in;
   logic [63:0]            max_ff, max_in;
   logic [63:0]            ns_ff, ns_in;
   logic [AddrWidth-1:0]   bkt_ff, bkt_in;
   logic [6:0]             pct_ff, pct_in;
   logic [AddrWidth-1:0]   idx_ff, idx_in;
   logic [COUNT_WIDTH+6:0] bound_ff, bound_in;

   logic                   accept;
   logic                   clear_all;
   logic                   mem_wr_en;
   logic [COUNT_WIDTH-1:0] mem_wr_data;
   logic [AddrWidth-1:0]   mem_rd_addr;
   logic [COUNT_WIDTH-1:0] mem_rd_data;
   acc_op_type             acc_op;
   logic                   acc_hit;
   logic [6:0]             pct_held;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // percent held between 1 and 99
   assign pct_held = (req_percent < PCT_MIN) ? PCT_MIN :
                     (req_percent > PCT_MAX) ? PCT_MAX : req_percent;

   // saturating increment of the bucket read back
   assign mem_wr_data = (mem_rd_data == CountMax) ? CountMax : mem_rd_data + 1'b1;

   // bucket store
   lgh_bucket_mem #(
      .DEPTH      (NUM_BUCKETS),
      .WIDTH      (COUNT_WIDTH),
      .ADDR_WIDTH (AddrWidth)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear_all),
      .wr_en   (mem_wr_en),
      .wr_addr (bkt_ff),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // cumulative walk unit
   lgh_accum_unit #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_acc (
      .clock   (clock),
      .op      (acc_op),
      .operand (mem_rd_data),
      .bound   (bound_ff),
      .hit     (acc_hit)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      answer_in    = answer_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      ns_in        = ns_ff;
      bkt_in       = bkt_ff;
      pct_in       = pct_ff;
      idx_in       = idx_ff;
      bound_in     = bound_ff;
      clear_all    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_rd_addr  = '0;
      acc_op       = ACC_HOLD;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               answer_in = '0;
               priority if (req_type == REQ_RECORD) begin
                  ns_in    = req_latency_ns;
                  bkt_in   = AddrWidth'(bucket_of(req_latency_ns, NUM_BUCKETS));
                  state_in = ST_REC_RD;
               end else if (req_type == REQ_QUERY && total_ff != '0) begin
                  pct_in   = pct_held;
                  state_in = ST_QRY_SETUP;
               end else if (req_type == REQ_CLEAR) begin
                  clear_all    = 1'b1;
                  total_in     = '0;
                  sum_in       = '0;
                  min_in       = '0;
                  max_in       = '0;
                  rsp_valid_in = 1'b1;
               end else begin
                  // empty query or unknown code
                  rsp_valid_in = 1'b1;
               end
            end
         end

         ST_REC_RD: begin
            mem_rd_addr = bkt_ff;
            state_in    = ST_REC_WR;
         end

         ST_REC_WR: begin
            mem_wr_en = 1'b1;
            total_in  = (total_ff == CountMax) ? CountMax : total_ff + 1'b1;
            sum_in    = sum_ff + ns_ff;
            if (total_ff == '0) begin
               min_in = ns_ff;
               max_in = ns_ff;
            end else begin
               if (ns_ff < min_ff) min_in = ns_ff;
               if (ns_ff > max_ff) max_in = ns_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_QRY_SETUP: begin
            bound_in    = (COUNT_WIDTH+7)'(total_ff) * (COUNT_WIDTH+7)'(pct_ff);
            mem_rd_addr = '0;
            idx_in      = '0;
            acc_op      = ACC_CLEAR;
            state_in    = ST_QRY_WALK;
         end

         ST_QRY_WALK: begin
            acc_op      = ACC_ADD;
            mem_rd_addr = (idx_ff == LastIdx) ? '0 : idx_ff + 1'b1;
            idx_in      = idx_ff + 1'b1;
            priority if (acc_hit) begin
               // bucket midpoint 1.5 * 2^(i+5)
               answer_in    = 64'd3 << (7'(idx_ff) + 7'd4);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (idx_ff == LastIdx) begin
               answer_in    = TopAnswer;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               // rank not reached yet, move on to the next bucket
               state_in     = ST_QRY_WALK;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         sum_ff       <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      answer_ff <= answer_in;
      ns_ff     <= ns_in;
      bkt_ff    <= bkt_in;
      pct_ff    <= pct_in;
      idx_ff    <= idx_in;
      bound_ff  <= bound_in;
   end

   // result ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_percentile_ns = answer_ff;
   assign rsp_sample_sum    = sum_ff;
   assign rsp_min_latency   = min_ff;
   assign rsp_max_latency   = max_ff;

   // count shown saturated to 32 bits
   generate
      if (COUNT_WIDTH > 32) begin : g_count_sat
         assign rsp_sample_count = (|total_ff[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF
                                                                : total_ff[31:0];
      end else begin : g_count_ext
         assign rsp_sample_count = 32'(total_ff);
      end
   endgenerate

endmodule

/* design/lgh_bucket_mem.sv */
// ----------------------------------------------------------------------------
// lgh_bucket_mem
// Bucket count store: one write and one registered read port, with a valid
// bit per entry so that reset and clear empty the whole store at once.
// ----------------------------------------------------------------------------
module lgh_bucket_mem #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned WIDTH = 32,
   parameter int unsigned ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // per-entry valid bits
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read, an entry never written reads as zero
   always_ff @(posedge clock) begin
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lgh_accum_unit.sv */
// ----------------------------------------------------------------------------
// lgh_accum_unit
// Accumulate and compare unit for the percentile walk: adds one
// bucket count scaled by 100 per step and flags when the bound is reached.
// ----------------------------------------------------------------------------
module lgh_accum_unit #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                     clock,
   input  lgh_pkg::acc_op_type      op,
   input  logic [COUNT_WIDTH-1:0]   operand,
   input  logic [COUNT_WIDTH+6:0]   bound,
   output logic                     hit
);
   import lgh_pkg::*;

   localparam int unsigned AccWidth = COUNT_WIDTH + 13;

   logic [AccWidth-1:0] acc_ff;
   logic [AccWidth-1:0] acc_in;
   logic [AccWidth-1:0] wide_op;
   logic [AccWidth-1:0] scaled;
   logic [AccWidth-1:0] sum;

   // operand times 100 as 64 + 32 + 4
   assign wide_op = AccWidth'(operand);
   assign scaled  = (wide_op << 6) + (wide_op << 5) + (wide_op << 2);
   assign sum     = acc_ff + scaled;

   // cumulative count (scaled) has reached count * percent
   assign hit = (sum >= AccWidth'(bound));

   // accumulator update
   always_comb begin
      unique case (op)
         ACC_CLEAR: acc_in = '0;
         ACC_ADD:   acc_in = sum;
         default:   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule
